// ----- rtl/lhct_pkg.sv -----
// Shared types and constants for the light hill-climb tracker.
package lhct_pkg;

    // Width of each configuration register and of the reported level
    localparam int CFG_W = 10;
    localparam int IDX_W = 2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [IDX_W-1:0] REG_MARGIN    = 2'd1;
    localparam logic [IDX_W-1:0] REG_TIMEOUT   = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 10'd150;
    localparam logic [CFG_W-1:0] MARGIN_RESET    = 10'd8;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET   = 10'd100;

    // Stepper command codes
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_CW   = 2'd1,
        STEP_CCW  = 2'd2
    } step_t;

    // Control flags of the climber
    typedef struct packed {
        logic tracking;
        logic step_dir;     // 0 clockwise, 1 counterclockwise
        logic awaiting;     // next item is the after-step sample
    } flags_t;

    // Active configuration
    typedef struct packed {
        logic [CFG_W-1:0] threshold;
        logic [CFG_W-1:0] margin;
        logic [CFG_W-1:0] timeout;
    } cfg_t;

    // One result item
    typedef struct packed {
        step_t            step_command;
        logic             tracking_mode;
        logic             expects_after;
        logic             reversed;
        logic [CFG_W-1:0] reported_level;
    } result_t;

    function automatic step_t dir_code(input logic dir);
        return dir ? STEP_CCW : STEP_CW;
    endfunction

endpackage

// ----- rtl/lhct_step.sv -----
// Next-state and result logic for one light sample.
module lhct_step #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0]    level,
    input  lhct_pkg::cfg_t            cfg,
    input  lhct_pkg::flags_t          flags,
    input  logic [lhct_pkg::CFG_W-1:0] lost_count,
    input  logic [SAMPLE_BITS-1:0]    before_level,
    output lhct_pkg::flags_t          flags_next,
    output logic [lhct_pkg::CFG_W-1:0] lost_next,
    output logic                      before_wr,
    output lhct_pkg::result_t         result
);

    // compare width: wide enough for level + margin without wrap
    localparam int CW = ((SAMPLE_BITS > lhct_pkg::CFG_W) ? SAMPLE_BITS : lhct_pkg::CFG_W) + 1;

    logic [CW-1:0]             level_ext;
    logic [CW-1:0]             before_ext;
    logic [CW-1:0]             thresh_ext;
    logic [CW-1:0]             sum_ext;
    logic [CW-1:0]             report_ext;
    logic [lhct_pkg::CFG_W-1:0] lost_inc;
    logic                      lit;
    logic                      drop;

    assign level_ext  = CW'(level);
    assign before_ext = CW'(before_level);
    assign thresh_ext = CW'(cfg.threshold);
    assign sum_ext    = level_ext + CW'(cfg.margin);
    assign lit        = level_ext >= thresh_ext;
    assign drop       = sum_ext < before_ext;
    assign lost_inc   = lost_count + 1'b1;

    always_comb begin
        flags_next            = flags;
        lost_next             = lost_count;
        before_wr             = 1'b0;
        report_ext            = level_ext;
        result.step_command   = lhct_pkg::STEP_NONE;
        result.reversed       = 1'b0;

        if (flags.awaiting) begin
            flags_next.awaiting = 1'b0;
            if (drop) begin
                result.step_command = lhct_pkg::dir_code(~flags.step_dir);
                flags_next.step_dir = ~flags.step_dir;
                result.reversed     = 1'b1;
                report_ext          = before_ext;
            end
        end else begin
            if (lit) begin
                lost_next = '0;
                if (!flags.tracking) begin
                    flags_next.step_dir = 1'b0;
                    flags_next.tracking = 1'b1;
                end
            end else if (lost_count < cfg.timeout) begin
                lost_next = lost_inc;
                if (lost_inc >= cfg.timeout) begin
                    flags_next.tracking = 1'b0;
                end
            end

            if (!flags_next.tracking) begin
                result.step_command = lhct_pkg::STEP_CW;
            end else if (lit) begin
                result.step_command = lhct_pkg::dir_code(flags_next.step_dir);
                before_wr           = 1'b1;
                flags_next.awaiting = 1'b1;
            end
        end

        result.tracking_mode  = flags_next.tracking;
        result.expects_after  = flags_next.awaiting;
        result.reported_level = report_ext[lhct_pkg::CFG_W-1:0];
    end

endmodule

// ----- rtl/light_hill_climb_tracker.sv -----
// Top level of the light hill-climb tracker: input stage, state and result register.
//
// Usage:
//   s_* channel takes one averaged light sample per item (valid/ready).
//   m_* channel returns one stepper command per item (valid/ready).
//   cfg_* is a plain write port: threshold (0), reverse margin (1),
//   lost timeout (2); other indexes are ignored. Write only while idle.
// Path: the accepting edge loads the input register; the result register
//   is loaded with the step decision when the item advances, which a low
//   m_ready on a held result delays.
// Throughput: one item per cycle while m_ready is high; the combinational decision
//   path from the input register to the state and result registers sets this.
// Stall: when m_ready is low the result holds; one more item may sit in
//   the input register, after which s_ready drops.
// Reset: aresetn low clears both stages, puts the climber in sweep mode,
//   clockwise, not awaiting an after-sample, and loads the lost counter and
//   the config registers with their defaults. The stored before level is
//   undefined until the first lit tracking sample writes it.
module light_hill_climb_tracker #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // sample input
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [SAMPLE_BITS-1:0]       s_light_level,
    // command output
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_step_command,
    output logic                         m_tracking_mode,
    output logic                         m_expects_after,
    output logic                         m_reversed,
    output logic [lhct_pkg::CFG_W-1:0]   m_reported_level,
    // configuration writes
    input  logic                         cfg_wr_en,
    input  logic [lhct_pkg::IDX_W-1:0]   cfg_index,
    input  logic [lhct_pkg::CFG_W-1:0]   cfg_wdata
);

    // config registers
    lhct_pkg::cfg_t cfg_reg;

    // input stage
    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] in_level_reg;

    // climber state
    lhct_pkg::flags_t           flags_reg;
    lhct_pkg::flags_t           flags_next;
    logic [lhct_pkg::CFG_W-1:0] lost_count_reg;
    logic [lhct_pkg::CFG_W-1:0] lost_count_next;
    logic [SAMPLE_BITS-1:0]     before_level_reg;
    logic                       before_wr;

    // result stage
    logic                 out_valid_reg;
    lhct_pkg::result_t    out_reg;
    lhct_pkg::result_t    result_next;

    logic advance;   // input-stage item moves into the result register

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Config port: writes land at once, unknown index dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.threshold <= lhct_pkg::THRESHOLD_RESET;
            cfg_reg.margin    <= lhct_pkg::MARGIN_RESET;
            cfg_reg.timeout   <= lhct_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                lhct_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_wdata;
                lhct_pkg::REG_MARGIN:    cfg_reg.margin    <= cfg_wdata;
                lhct_pkg::REG_TIMEOUT:   cfg_reg.timeout   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_level_reg <= s_light_level;
        end
    end

    // Decision logic for the item in the input register
    lhct_step #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_step (
        .level        (in_level_reg),
        .cfg          (cfg_reg),
        .flags        (flags_reg),
        .lost_count   (lost_count_reg),
        .before_level (before_level_reg),
        .flags_next   (flags_next),
        .lost_next    (lost_count_next),
        .before_wr    (before_wr),
        .result       (result_next)
    );

    // State only moves when an item advances, so each item sees the
    // state left by the one before it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flags_reg      <= '0;
            lost_count_reg <= lhct_pkg::TIMEOUT_RESET;
        end else if (advance) begin
            flags_reg      <= flags_next;
            lost_count_reg <= lost_count_next;
        end
    end

    // before level: payload, no reset
    always_ff @(posedge aclk) begin
        if (advance && before_wr) begin
            before_level_reg <= in_level_reg;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_step_command   = out_reg.step_command;
    assign m_tracking_mode  = out_reg.tracking_mode;
    assign m_expects_after  = out_reg.expects_after;
    assign m_reversed       = out_reg.reversed;
    assign m_reported_level = out_reg.reported_level;

endmodule

// ----- rtl/lhct_checker.sv -----
// Port-level assertions for the light hill-climb tracker, with bind.
module lhct_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_step_command,
    input logic       m_tracking_mode,
    input logic       m_expects_after,
    input logic       m_reversed
);

    // no result straight out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // sweep mode always steps clockwise
    a_sweep_cw: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_tracking_mode) |-> (m_step_command == lhct_pkg::STEP_CW))
        else $error("sweep item without clockwise step");

    // a pending after-sample follows a real step while tracking
    a_after_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_expects_after) |->
            (m_tracking_mode && m_step_command != lhct_pkg::STEP_NONE && !m_reversed))
        else $error("after-sample expected without a tracking step");

    // a reversal steps, stays in tracking and closes the pair
    a_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_reversed) |->
            (m_tracking_mode && !m_expects_after && m_step_command != lhct_pkg::STEP_NONE))
        else $error("bad reversal item");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_step_command) && $stable(m_reversed)))
        else $error("stalled result changed");

endmodule

bind light_hill_climb_tracker lhct_checker u_lhct_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_step_command  (m_step_command),
    .m_tracking_mode (m_tracking_mode),
    .m_expects_after (m_expects_after),
    .m_reversed      (m_reversed)
);

// ----- tb/tb_light_hill_climb_tracker.sv -----
// Self-checking testbench for the light hill-climb tracker: predictor, scoreboard and stimulus.
module tb_light_hill_climb_tracker;

    // Index with no register behind it; writes to it must be ignored
    localparam logic [lhct_pkg::IDX_W-1:0] REG_NONE = 2'd3;

    localparam int LEVEL_MAX    = 1023;
    localparam int ITEMS_PER_SET = 150;
    localparam int SETTING_SETS  = 7;
    localparam int DRAIN_LIMIT   = 20000;

    // Predicts each result item from the accepted sample and keeps the queue
    // of results still owed by the block.
    class tracker_scoreboard;
        // active settings
        logic [lhct_pkg::CFG_W-1:0] thr;
        logic [lhct_pkg::CFG_W-1:0] margin;
        logic [lhct_pkg::CFG_W-1:0] timeout;
        // climber state
        logic                       tracking;
        logic                       step_dir;      // 0 cw, 1 ccw
        logic                       awaiting;
        logic [lhct_pkg::CFG_W-1:0] lost_cnt;
        logic [lhct_pkg::CFG_W-1:0] before_lvl;
        lhct_pkg::result_t          owed[$];
        int                         errors;
        int                         n_samples;
        int                         n_checked;
        int                         n_reversals;
        int                         n_sweep_steps;
        int                         n_climb_steps;
        int                         n_dark_holds;
        int                         n_fallbacks;

        function new();
            thr        = lhct_pkg::THRESHOLD_RESET;
            margin     = lhct_pkg::MARGIN_RESET;
            timeout    = lhct_pkg::TIMEOUT_RESET;
            tracking   = 1'b0;
            step_dir   = 1'b0;
            awaiting   = 1'b0;
            lost_cnt   = lhct_pkg::TIMEOUT_RESET;
            before_lvl = '0;
            errors     = 0;
            n_samples  = 0;
            n_checked  = 0;
            n_reversals   = 0;
            n_sweep_steps = 0;
            n_climb_steps = 0;
            n_dark_holds  = 0;
            n_fallbacks   = 0;
        endfunction

        function void write_reg(input logic [lhct_pkg::IDX_W-1:0] idx,
                                input logic [lhct_pkg::CFG_W-1:0] val);
            case (idx)
                lhct_pkg::REG_THRESHOLD: thr = val;
                lhct_pkg::REG_MARGIN:    margin = val;
                lhct_pkg::REG_TIMEOUT:   timeout = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void note_sample(input logic [lhct_pkg::CFG_W-1:0] lvl);
            lhct_pkg::result_t        r;
            logic                     lit;
            logic [lhct_pkg::CFG_W:0] sum;
            r.step_command   = lhct_pkg::STEP_NONE;
            r.reversed       = 1'b0;
            r.reported_level = lvl;
            n_samples++;
            if (awaiting) begin
                // after-step reading: only the reversal test applies
                awaiting = 1'b0;
                sum = {1'b0, lvl} + {1'b0, margin};
                if (sum < {1'b0, before_lvl}) begin
                    step_dir         = ~step_dir;
                    r.step_command   = step_dir ? lhct_pkg::STEP_CCW : lhct_pkg::STEP_CW;
                    r.reversed       = 1'b1;
                    r.reported_level = before_lvl;
                    n_reversals++;
                end
            end else begin
                lit = (lvl >= thr);
                if (lit) begin
                    lost_cnt = '0;
                    if (!tracking) begin
                        step_dir = 1'b0;
                        tracking = 1'b1;
                    end
                end else if (lost_cnt < timeout) begin
                    lost_cnt = lost_cnt + 1'b1;
                    if (lost_cnt >= timeout && tracking) begin
                        tracking = 1'b0;
                        n_fallbacks++;
                    end
                end
                if (!tracking) begin
                    r.step_command = lhct_pkg::STEP_CW;
                    n_sweep_steps++;
                end else if (lit) begin
                    r.step_command = step_dir ? lhct_pkg::STEP_CCW : lhct_pkg::STEP_CW;
                    before_lvl     = lvl;
                    awaiting       = 1'b1;
                    n_climb_steps++;
                end else begin
                    n_dark_holds++;
                end
            end
            r.tracking_mode = tracking;
            r.expects_after = awaiting;
            owed.push_back(r);
        endfunction

        function void compare_field(input string name,
                                    input logic [lhct_pkg::CFG_W-1:0] want,
                                    input logic [lhct_pkg::CFG_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(input lhct_pkg::result_t got);
            lhct_pkg::result_t want;
            if (owed.size() == 0) begin
                $display("%0t: result item with nothing expected (step %0d, level %0d)",
                         $time, got.step_command, got.reported_level);
                errors++;
                return;
            end
            want = owed.pop_front();
            n_checked++;
            compare_field("step_command",   lhct_pkg::CFG_W'(want.step_command),
                          lhct_pkg::CFG_W'(got.step_command));
            compare_field("tracking_mode",  lhct_pkg::CFG_W'(want.tracking_mode),
                          lhct_pkg::CFG_W'(got.tracking_mode));
            compare_field("expects_after",  lhct_pkg::CFG_W'(want.expects_after),
                          lhct_pkg::CFG_W'(got.expects_after));
            compare_field("reversed",       lhct_pkg::CFG_W'(want.reversed),
                          lhct_pkg::CFG_W'(got.reversed));
            compare_field("reported_level", want.reported_level, got.reported_level);
        endfunction
    endclass

    // Clock, reset and all block inputs start at known values
    logic                             aclk          = 1'b0;
    logic                             aresetn       = 1'b0;
    logic                             s_valid       = 1'b0;
    logic                             s_ready;
    logic [lhct_pkg::CFG_W-1:0]       s_light_level = '0;
    logic                             m_valid;
    logic                             m_ready       = 1'b0;
    logic [1:0]                       m_step_command;
    logic                             m_tracking_mode;
    logic                             m_expects_after;
    logic                             m_reversed;
    logic [lhct_pkg::CFG_W-1:0]       m_reported_level;
    logic                             cfg_wr_en     = 1'b0;
    logic [lhct_pkg::IDX_W-1:0]       cfg_index     = '0;
    logic [lhct_pkg::CFG_W-1:0]       cfg_wdata     = '0;

    tracker_scoreboard sb;
    lhct_pkg::result_t seen_result;
    int                tx_idle_pct = 0;    // chance in percent that the sender holds off
    int                rx_idle_pct = 0;    // chance in percent that the receiver stalls

    light_hill_climb_tracker #(.SAMPLE_BITS(10)) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_light_level    (s_light_level),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_step_command   (m_step_command),
        .m_tracking_mode  (m_tracking_mode),
        .m_expects_after  (m_expects_after),
        .m_reversed       (m_reversed),
        .m_reported_level (m_reported_level),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Result side: check every accepted item, then pick ready for the next cycle.
    // Values read here are the ones held just before the edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                seen_result.step_command   = lhct_pkg::step_t'(m_step_command);
                seen_result.tracking_mode  = m_tracking_mode;
                seen_result.expects_after  = m_expects_after;
                seen_result.reversed       = m_reversed;
                seen_result.reported_level = m_reported_level;
                sb.check_result(seen_result);
            end
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Present one sample and hold it until taken; the predictor sees it at the
    // accepting edge so the next sample can be shaped on the updated state.
    task automatic send_level(input logic [lhct_pkg::CFG_W-1:0] lvl);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_light_level <= lvl;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_sample(lvl);
    endtask

    // Stop sending and wait until every owed result is back, then let the
    // two-stage pipe settle before returning.
    task automatic drain_results();
        int waited;
        waited  = 0;
        s_valid <= 1'b0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
    endtask

    // One register write; the enable drops on the following edge so that
    // back-to-back calls never assign it twice in one step.
    task automatic write_reg(input logic [lhct_pkg::IDX_W-1:0] idx,
                             input logic [lhct_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [lhct_pkg::CFG_W-1:0] thr,
                                  input logic [lhct_pkg::CFG_W-1:0] mg,
                                  input logic [lhct_pkg::CFG_W-1:0] to);
        write_reg(lhct_pkg::REG_THRESHOLD, thr);
        write_reg(lhct_pkg::REG_MARGIN, mg);
        write_reg(lhct_pkg::REG_TIMEOUT, to);
    endtask

    // Next random sample. While an after-step reading is due, most samples sit
    // right around the reversal boundary; otherwise mostly lit or dark around
    // the threshold, with some plain noise over the whole range.
    function automatic logic [lhct_pkg::CFG_W-1:0] next_level();
        int v;
        int pick;
        pick = int'($urandom_range(99));
        if (sb.awaiting) begin
            if (pick < 10)
                v = int'($urandom_range(LEVEL_MAX));
            else if (pick < 20)
                v = int'(sb.before_lvl);
            else
                v = int'(sb.before_lvl) - int'(sb.margin) + int'($urandom_range(6)) - 3;
        end else begin
            if (pick < 55)
                v = int'($urandom_range(int'(sb.thr), LEVEL_MAX));
            else if (pick < 85 && sb.thr > 0)
                v = int'($urandom_range(0, int'(sb.thr) - 1));
            else if (pick < 92)
                v = int'(sb.thr) - int'($urandom_range(1));
            else
                v = int'($urandom_range(LEVEL_MAX));
        end
        if (v < 0)
            v = 0;
        if (v > LEVEL_MAX)
            v = LEVEL_MAX;
        return v[lhct_pkg::CFG_W-1:0];
    endfunction

    initial begin
        int                         item_no;
        logic [lhct_pkg::CFG_W-1:0] thr;
        logic [lhct_pkg::CFG_W-1:0] mg;
        logic [lhct_pkg::CFG_W-1:0] to;

        sb = new();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // ---- directed part, reset settings (150 / 8 / 100) ----
        send_level(10'd0);       // dark while sweeping: sweep step
        send_level(10'd149);     // one below threshold
        send_level(10'd150);     // exactly at threshold: enters tracking, cw step
        send_level(10'd142);     // after reading, 142+8 == 150: no reversal
        send_level(10'd1023);    // top of range, climb cw
        send_level(10'd0);       // big drop: step back ccw and flip
        send_level(10'd600);     // climb ccw
        send_level(10'd591);     // 599 < 600: flip back to cw
        send_level(10'd100);     // dark in tracking: no step
        send_level(10'd1023);
        send_level(10'd1023);    // after reading equal: no reversal
        drain_results();

        // zero margin, short timeout
        apply_settings(10'd300, 10'd0, 10'd2);
        send_level(10'd1023);
        send_level(10'd1022);    // any drop reverses with zero margin
        send_level(10'd0);
        send_level(10'd0);       // second dark tick: falls back to sweep
        send_level(10'd299);     // count already at timeout, keeps sweeping
        send_level(10'd300);     // light regained: direction forced cw
        send_level(10'd300);
        drain_results();

        // lower the timeout below the running count while tracking
        write_reg(lhct_pkg::REG_TIMEOUT, 10'd5);
        send_level(10'd0);
        send_level(10'd0);
        send_level(10'd0);       // count 3, still tracking
        drain_results();
        write_reg(lhct_pkg::REG_TIMEOUT, 10'd2);
        write_reg(REG_NONE, 10'd1023);   // no register there: must not change anything
        send_level(10'd0);       // count above timeout: mode and count unchanged
        send_level(10'd0);
        drain_results();

        // ---- random part: several settings, extremes first ----
        item_no = 0;
        for (int set_no = 0; set_no < SETTING_SETS; set_no++) begin
            case (set_no)
                0: begin thr = 10'd0;    mg = 10'd0;    to = 10'd1;    end
                1: begin thr = 10'd1023; mg = 10'd1023; to = 10'd1023; end
                2: begin thr = 10'd512;  mg = 10'd16;   to = 10'd3;    end
                default: begin
                    thr = lhct_pkg::CFG_W'($urandom_range(LEVEL_MAX));
                    mg  = ($urandom_range(3) == 0)
                        ? lhct_pkg::CFG_W'($urandom_range(LEVEL_MAX))
                        : lhct_pkg::CFG_W'($urandom_range(40));
                    to  = ($urandom_range(3) == 0)
                        ? lhct_pkg::CFG_W'($urandom_range(1, LEVEL_MAX))
                        : lhct_pkg::CFG_W'($urandom_range(1, 12));
                end
            endcase
            apply_settings(thr, mg, to);
            if (set_no == 4)
                write_reg(REG_NONE, lhct_pkg::CFG_W'($urandom_range(LEVEL_MAX)));

            for (int k = 0; k < ITEMS_PER_SET; k++) begin
                // idle pattern: slow receiver, then slow sender, then full rate
                if (item_no < 350) begin
                    tx_idle_pct = 23;
                    rx_idle_pct = 73;
                end else if (item_no < 700) begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 23;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                send_level(next_level());
                item_no++;
            end
            // hold off until the pipe is empty before touching the registers
            drain_results();
        end

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, sb.pending());
            sb.errors++;
        end
        $display("Covered %0d samples, %0d results checked over %0d setting sets.",
                 sb.n_samples, sb.n_checked, SETTING_SETS);
        $display("Reversals %0d, climb steps %0d, sweep steps %0d, dark holds %0d, fallbacks %0d.",
                 sb.n_reversals, sb.n_climb_steps, sb.n_sweep_steps, sb.n_dark_holds,
                 sb.n_fallbacks);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this stimulus
    initial begin
        #3200000;
        $display("%0t: watchdog expired, run did not finish", $time);
        $display("TEST FAILED");
        $finish;
    end

endmodule
